/* rtl/tcr_pkg.sv */
// Shared types and constants for the ring-road traffic automaton.
`default_nettype none

package tcr_pkg;

  // Field widths
  localparam int CELL_IDX_W = 6;
  localparam int SPD_W      = 3;
  localparam int MASK_W     = 64;
  localparam int TOTAL_W    = 9;
  localparam int COUNT_W    = 7;

  // Road length default, cells looked at ahead (top speed), cells per sum group
  localparam int ROAD_LEN_DEF = 64;
  localparam int LOOK         = (1 << SPD_W) - 1;
  localparam int GRP          = 8;

  localparam logic [SPD_W-1:0] MAX_SPEED_RST = 3'd5;

  // Request codes
  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_READ = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  typedef logic [CELL_IDX_W-1:0] tcr_idx_t;
  typedef logic [SPD_W-1:0]      tcr_spd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOVE,
    ST_SUM
  } tcr_state_t;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic load_en;
    logic vel_en;
    logic move_en;
  } tcr_cell_ctl_t;

  typedef struct packed {
    logic [1:0]            req_type;
    logic [CELL_IDX_W-1:0] cell_index;
    logic                  cell_occupied;
    logic [SPD_W-1:0]      cell_speed;
    logic [MASK_W-1:0]     slow_mask;
  } tcr_in_t;

  typedef struct packed {
    logic               rsp_occupied;
    logic [SPD_W-1:0]   rsp_speed;
    logic [TOTAL_W-1:0] total_speed;
    logic [COUNT_W-1:0] vehicle_count;
  } tcr_out_t;

endpackage

`default_nettype wire

/* rtl/tcr_cell.sv */
// One road cell: holds occupancy and speed, computes its velocity and gathers arrivals.
`default_nettype none

module tcr_cell (
  input  wire logic                                          clk,
  input  wire logic                                          rst_n,
  input  wire tcr_pkg::tcr_cell_ctl_t                        ctl,
  input  wire logic                                          ld_occ,
  input  wire tcr_pkg::tcr_spd_t                             ld_spd,
  input  wire tcr_pkg::tcr_spd_t                             max_speed,
  input  wire logic                                          slow,
  input  wire logic [tcr_pkg::LOOK-1:0]                      ahead_occ,
  input  wire logic [tcr_pkg::LOOK:0]                        prev_occ,
  input  wire logic [tcr_pkg::LOOK:0][tcr_pkg::SPD_W-1:0]    prev_vel,
  output logic                                               occ,
  output tcr_pkg::tcr_spd_t                                  spd,
  output tcr_pkg::tcr_spd_t                                  vel
);

  logic              occ_r, occ_nxt;
  tcr_pkg::tcr_spd_t spd_r, spd_nxt;
  tcr_pkg::tcr_spd_t vel_r, vel_nxt;

  logic [tcr_pkg::SPD_W:0] v_acc, v_cap, v_lim, v_fin;
  tcr_pkg::tcr_spd_t       gap;
  logic                    open;
  logic                    hit;
  tcr_pkg::tcr_spd_t       spd_in;

  // Velocity: accelerate, cap, limit by free cells ahead, optional slowdown
  always_comb begin
    v_acc = {1'b0, spd_r} + 4'd1;
    v_cap = (v_acc > {1'b0, max_speed}) ? {1'b0, max_speed} : v_acc;
    gap   = '0;
    open  = 1'b1;
    for (int k = 0; k < tcr_pkg::LOOK; k++) begin
      if (open && !ahead_occ[k]) begin
        gap = gap + 3'd1;
      end else begin
        open = 1'b0;
      end
    end
    v_lim   = ({1'b0, gap} < v_cap) ? {1'b0, gap} : v_cap;
    v_fin   = (v_lim != '0 && slow) ? v_lim - 4'd1 : v_lim;
    vel_nxt = occ_r ? v_fin[tcr_pkg::SPD_W-1:0] : '0;
  end

  // Arrival: the predecessor k cells back lands here when its velocity is k
  always_comb begin
    hit    = 1'b0;
    spd_in = '0;
    for (int k = 0; k <= tcr_pkg::LOOK; k++) begin
      if (prev_occ[k] && prev_vel[k] == tcr_pkg::tcr_spd_t'(k)) begin
        hit    = 1'b1;
        spd_in = spd_in | prev_vel[k];
      end
    end
  end

  // Next cell contents
  always_comb begin
    occ_nxt = occ_r;
    spd_nxt = spd_r;
    if (ctl.load_en) begin
      occ_nxt = ld_occ;
      spd_nxt = ld_spd;
    end else if (ctl.move_en) begin
      occ_nxt = hit;
      spd_nxt = spd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
      spd_r <= '0;
    end else begin
      occ_r <= occ_nxt;
      spd_r <= spd_nxt;
    end
  end

  // Velocity is rewritten at the start of every tick
  always_ff @(posedge clk) begin
    if (ctl.vel_en) begin
      vel_r <= vel_nxt;
    end
  end

  assign occ = occ_r;
  assign spd = spd_r;
  assign vel = vel_r;

endmodule

`default_nettype wire

/* rtl/tcr_sum.sv */
// Accumulator for total speed and vehicle count, one group of cells per cycle while enabled.
`default_nettype none

module tcr_sum (
  input  wire logic                                        clk,
  input  wire logic                                        rst_n,
  input  wire logic                                        clr,
  input  wire logic                                        en,
  input  wire logic [tcr_pkg::GRP-1:0]                     grp_occ,
  input  wire logic [tcr_pkg::GRP-1:0][tcr_pkg::SPD_W-1:0] grp_spd,
  output logic [tcr_pkg::TOTAL_W-1:0]                      total,
  output logic [tcr_pkg::COUNT_W-1:0]                      count
);

  localparam int GS_W = tcr_pkg::SPD_W + $clog2(tcr_pkg::GRP);
  localparam int GC_W = $clog2(tcr_pkg::GRP + 1);

  logic [tcr_pkg::TOTAL_W-1:0] total_r, total_nxt;
  logic [tcr_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [GS_W-1:0]             gsum;
  logic [GC_W-1:0]             gcnt;

  // Group sum; empty cells hold speed zero
  always_comb begin
    gsum = '0;
    gcnt = '0;
    for (int j = 0; j < tcr_pkg::GRP; j++) begin
      gsum = gsum + GS_W'(grp_spd[j]);
      gcnt = gcnt + GC_W'(grp_occ[j]);
    end
  end

  always_comb begin
    total_nxt = total_r;
    count_nxt = count_r;
    if (clr) begin
      total_nxt = '0;
      count_nxt = '0;
    end else if (en) begin
      total_nxt = total_r + tcr_pkg::TOTAL_W'(gsum);
      count_nxt = count_r + tcr_pkg::COUNT_W'(gcnt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      count_r <= '0;
    end else begin
      total_r <= total_nxt;
      count_r <= count_nxt;
    end
  end

  assign total = total_r;
  assign count = count_r;

endmodule

`default_nettype wire

/* rtl/traffic_ca_ring_step.sv */
// Top level of the ring-road traffic automaton: cell row, tick sequencer, result register.
//
//   port group   direction  handshake              payload
//   in_          input      start high, busy low   in_data  (tcr_in_t)
//   out_         output     out_valid strobe       out_data (tcr_out_t)
//   cfg_         input      cfg_we                 cfg_wdata (max speed)
//
// For load, read and unknown requests the result appears the cycle after
// the item is taken and the next item can be taken in that same cycle.
// A tick runs in steps: velocity capture on accept, a move step in the cell row,
// then the summing unit adds the cells in groups of 8, one group after another.
// busy is high through the move and sum cycles. Reset is synchronous, active low, and
// leaves the road empty and max speed at 5. The result is shown for one cycle only.
`default_nettype none

module traffic_ca_ring_step #(
  parameter int ROAD_LEN = tcr_pkg::ROAD_LEN_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire tcr_pkg::tcr_in_t  in_data,
  output logic                   out_valid,
  output tcr_pkg::tcr_out_t      out_data,
  input  wire logic              cfg_we,
  input  wire tcr_pkg::tcr_spd_t cfg_wdata
);

  localparam int IW     = $clog2(ROAD_LEN);
  localparam int NGRP   = (ROAD_LEN + tcr_pkg::GRP - 1) / tcr_pkg::GRP;
  localparam int GW     = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int PAD    = NGRP * tcr_pkg::GRP;
  localparam int LOOK   = tcr_pkg::LOOK;
  localparam int SPD_W  = tcr_pkg::SPD_W;

  // Config register
  tcr_pkg::tcr_spd_t max_speed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r <= tcr_pkg::MAX_SPEED_RST;
    end else if (cfg_we) begin
      max_speed_r <= cfg_wdata;
    end
  end

  // Request decode
  logic              acc, tick_acc, in_road;
  logic [IW-1:0]     idx_s;
  logic              ld_occ;
  tcr_pkg::tcr_spd_t ld_spd;

  assign acc      = start && !busy;
  assign tick_acc = acc && (in_data.req_type == tcr_pkg::REQ_TICK);
  assign in_road  = ({1'b0, in_data.cell_index} < (tcr_pkg::CELL_IDX_W + 1)'(ROAD_LEN));
  assign idx_s    = in_data.cell_index[IW-1:0];
  assign ld_occ   = in_data.cell_occupied;
  assign ld_spd   = !in_data.cell_occupied ? '0 :
                    (in_data.cell_speed > max_speed_r) ? max_speed_r : in_data.cell_speed;

  // Sequencer
  tcr_pkg::tcr_state_t state_r, state_nxt;
  logic [GW-1:0]       grp_r, grp_nxt;
  logic                sum_clr, sum_en, done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcr_pkg::ST_IDLE;
      grp_r   <= '0;
    end else begin
      state_r <= state_nxt;
      grp_r   <= grp_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    grp_nxt   = grp_r;
    sum_clr   = 1'b0;
    sum_en    = 1'b0;
    done      = 1'b0;
    case (state_r)
      tcr_pkg::ST_IDLE: begin
        if (tick_acc) begin
          state_nxt = tcr_pkg::ST_MOVE;
        end
      end
      tcr_pkg::ST_MOVE: begin
        sum_clr   = 1'b1;
        grp_nxt   = '0;
        state_nxt = tcr_pkg::ST_SUM;
      end
      tcr_pkg::ST_SUM: begin
        sum_en = 1'b1;
        if (grp_r == GW'(NGRP - 1)) begin
          done      = 1'b1;
          state_nxt = tcr_pkg::ST_IDLE;
        end else begin
          grp_nxt = grp_r + 1'b1;
        end
      end
      default: begin
        state_nxt = tcr_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != tcr_pkg::ST_IDLE);

  // Cell row
  logic [ROAD_LEN-1:0]                      occ_v;
  logic [ROAD_LEN-1:0][SPD_W-1:0]           spd_v;
  logic [ROAD_LEN-1:0][SPD_W-1:0]           vel_v;
  logic [ROAD_LEN-1:0][LOOK-1:0]            ahead_v;
  logic [ROAD_LEN-1:0][LOOK:0]              prev_occ_v;
  logic [ROAD_LEN-1:0][LOOK:0][SPD_W-1:0]   prev_vel_v;

  for (genvar i = 0; i < ROAD_LEN; i++) begin : g_cell
    tcr_pkg::tcr_cell_ctl_t ctl;

    // Cells ahead on the ring
    for (genvar k = 0; k < LOOK; k++) begin : g_ahead
      localparam int A = (i + k + 1) % ROAD_LEN;
      assign ahead_v[i][k] = occ_v[A];
    end

    // Cells behind on the ring, self included
    for (genvar k = 0; k <= LOOK; k++) begin : g_prev
      localparam int P = (i + ROAD_LEN * (LOOK + 1) - k) % ROAD_LEN;
      assign prev_occ_v[i][k] = occ_v[P];
      assign prev_vel_v[i][k] = vel_v[P];
    end

    assign ctl.load_en = acc && (in_data.req_type == tcr_pkg::REQ_LOAD) && in_road &&
                         (in_data.cell_index == tcr_pkg::tcr_idx_t'(i));
    assign ctl.vel_en  = tick_acc;
    assign ctl.move_en = (state_r == tcr_pkg::ST_MOVE);

    tcr_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .ld_occ    (ld_occ),
      .ld_spd    (ld_spd),
      .max_speed (max_speed_r),
      .slow      (in_data.slow_mask[i]),
      .ahead_occ (ahead_v[i]),
      .prev_occ  (prev_occ_v[i]),
      .prev_vel  (prev_vel_v[i]),
      .occ       (occ_v[i]),
      .spd       (spd_v[i]),
      .vel       (vel_v[i])
    );
  end

  // Group the cells for summing, padding the last group with empty cells
  logic [PAD-1:0]                             occ_pad;
  logic [PAD-1:0][SPD_W-1:0]                  spd_pad;
  logic [tcr_pkg::GRP-1:0]                    grp_occ;
  logic [tcr_pkg::GRP-1:0][SPD_W-1:0]         grp_spd;
  logic [tcr_pkg::TOTAL_W-1:0]                sum_total;
  logic [tcr_pkg::COUNT_W-1:0]                sum_count;

  for (genvar j = 0; j < PAD; j++) begin : g_pad
    if (j < ROAD_LEN) begin : g_real
      assign occ_pad[j] = occ_v[j];
      assign spd_pad[j] = spd_v[j];
    end else begin : g_fill
      assign occ_pad[j] = 1'b0;
      assign spd_pad[j] = '0;
    end
  end

  assign grp_occ = occ_pad[grp_r * tcr_pkg::GRP +: tcr_pkg::GRP];
  assign grp_spd = spd_pad[grp_r * tcr_pkg::GRP +: tcr_pkg::GRP];

  tcr_sum u_sum (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (sum_clr),
    .en      (sum_en),
    .grp_occ (grp_occ),
    .grp_spd (grp_spd),
    .total   (sum_total),
    .count   (sum_count)
  );

  // Load/read response, taken at accept
  logic              rsp_occ_nxt;
  tcr_pkg::tcr_spd_t rsp_spd_nxt;

  always_comb begin
    rsp_occ_nxt = 1'b0;
    rsp_spd_nxt = '0;
    if (in_road) begin
      if (in_data.req_type == tcr_pkg::REQ_LOAD) begin
        rsp_occ_nxt = ld_occ;
        rsp_spd_nxt = ld_spd;
      end else if (in_data.req_type == tcr_pkg::REQ_READ) begin
        rsp_occ_nxt = occ_v[idx_s];
        rsp_spd_nxt = occ_v[idx_s] ? spd_v[idx_s] : '0;
      end
    end
  end

  // Result register
  logic              out_valid_r, tick_rsp_r;
  logic              rsp_occ_r;
  tcr_pkg::tcr_spd_t rsp_spd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      tick_rsp_r  <= 1'b0;
    end else begin
      out_valid_r <= (acc && !tick_acc) || done;
      tick_rsp_r  <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !tick_acc) begin
      rsp_occ_r <= rsp_occ_nxt;
      rsp_spd_r <= rsp_spd_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_data.rsp_occupied  = tick_rsp_r ? 1'b0 : rsp_occ_r;
  assign out_data.rsp_speed     = tick_rsp_r ? '0 : rsp_spd_r;
  assign out_data.total_speed   = tick_rsp_r ? sum_total : '0;
  assign out_data.vehicle_count = tick_rsp_r ? sum_count : '0;

  // Checks
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past((acc && !tick_acc) || done))
    else $error("result without a finished item");

  a_tick_move: assert property (@(posedge clk) disable iff (!rst_n)
    tick_acc |=> (state_r == tcr_pkg::ST_MOVE))
    else $error("tick did not enter the move cycle");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && tick_rsp_r) |-> (out_data.vehicle_count <= tcr_pkg::COUNT_W'(ROAD_LEN)))
    else $error("vehicle count exceeds road length");

  a_speed_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && tick_rsp_r) |->
      (out_data.total_speed <= tcr_pkg::TOTAL_W'(ROAD_LEN * LOOK)))
    else $error("total speed out of range");

endmodule

`default_nettype wire
